### rtl/core/prcc_pkg.sv
// Package for the packet rule chain classifier.
// Holds field widths, transfer structs, rule codes and default parameters.
// Has no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package prcc_pkg;

  localparam int CHAIN_DEPTH_DEF = 32;
  localparam int HOOK_COUNT_DEF  = 5;
  localparam int RULE_IDS_DEF    = 256;

  localparam int HOOK_EN_W = 5;
  localparam int ID_W      = 8;
  localparam int CTRL_W    = 40;
  localparam int WORD_W    = 64;

  localparam logic       FUNC_CLASSIFY = 1'b0;
  localparam logic       FUNC_WRITE    = 1'b1;

  localparam logic [1:0] SEL_ADDR = 2'd0;
  localparam logic [1:0] SEL_MASK = 2'd1;
  localparam logic [1:0] SEL_PORT = 2'd2;
  localparam logic [1:0] SEL_CTRL = 2'd3;

  localparam logic [1:0] MT_ANY    = 2'd1;
  localparam logic [1:0] MT_MASKED = 2'd2;
  localparam logic [1:0] MT_RANGE  = 2'd2;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  localparam logic [7:0] PMASK_TCP  = 8'h01;
  localparam logic [7:0] PMASK_UDP  = 8'h02;
  localparam logic [7:0] PMASK_ICMP = 8'h04;

  typedef struct packed {
    logic        func;
    logic [2:0]  hook;
    logic [4:0]  slot;
    logic [1:0]  word_sel;
    logic [63:0] word_data;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [7:0]  protocol;
    logic [15:0] sport;
    logic [15:0] dport;
    logic        ports_ok;
  } in_item_t;

  typedef struct packed {
    logic        matched;
    logic [1:0]  action;
    logic [7:0]  rule_id;
    logic [63:0] hit_count;
  } out_item_t;

endpackage
`default_nettype wire

### rtl/core/packet_rule_chain_classifier_core.sv
// Top level of the packet rule chain classifier: sequencer, rule stores, hit counters.
// Depends on prcc_pkg, prcc_ram and prcc_match.
//
// The input channel (in_valid, in_ready, in_item) carries two kinds of item. A write
// item stores one rule word at a hook and slot, if both are in range; it gives no
// result. A classify item scans the chain of its hook from slot 0, one rule read from
// the stores per cycle, stopping at the first hit, at a rule id of zero or at the end
// of the chain; a disabled hook or a clear ports_ok skips the scan.
// A classify transfer produces exactly one result on out_valid, out_ready, out_item.
// After a hit, the rule id is reduced by RULE_IDS until it is below RULE_IDS, the hit
// counter at that index is read and written back one higher, saturating, and the
// result is loaded into the output register. The block is not ready while a classify
// is in progress. The user must write the hook_enable register through cfg_we and
// cfg_wdata only while idle; the block itself does not enforce this.
// Synchronous reset clears the sequencer, the enables, the valid bits of the rule
// control words and of the hit counters, so every chain is empty and counts are zero.
// A finished result waits in the output register while the receiver stalls; the
// next item may be accepted meanwhile, but its result waits until that transfer.
`timescale 1ns / 1ps
`default_nettype none
module packet_rule_chain_classifier_core #(
  parameter int CHAIN_DEPTH = prcc_pkg::CHAIN_DEPTH_DEF,
  parameter int HOOK_COUNT  = prcc_pkg::HOOK_COUNT_DEF,
  parameter int RULE_IDS    = prcc_pkg::RULE_IDS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire prcc_pkg::in_item_t             in_item,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output prcc_pkg::out_item_t                 out_item,
  input  wire logic                           cfg_we,
  input  wire logic [prcc_pkg::HOOK_EN_W-1:0] cfg_wdata
);

  localparam int SLOTS     = HOOK_COUNT * CHAIN_DEPTH;
  localparam int AW        = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SW        = $clog2(CHAIN_DEPTH + 1);
  localparam int CNT_DEPTH = (RULE_IDS < 256) ? RULE_IDS : 256;
  localparam int CW        = (CNT_DEPTH > 1) ? $clog2(CNT_DEPTH) : 1;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SCAN = 6'b000010,
    ST_MOD  = 6'b000100,
    ST_CRD  = 6'b001000,
    ST_CWR  = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  state_t               state_r, state_nxt;
  prcc_pkg::in_item_t   pkt_r, pkt_nxt;
  logic [AW-1:0]        base_r, base_nxt;
  logic [SW-1:0]        s_r, s_nxt;
  logic                 pend_r, pend_nxt;
  logic                 rdv_r, rdv_nxt;
  logic                 cvld_r, cvld_nxt;
  logic [7:0]           ci_r, ci_nxt;
  logic [1:0]           act_r, act_nxt;
  logic [7:0]           id_r, id_nxt;
  prcc_pkg::out_item_t  res_r, res_nxt;
  prcc_pkg::out_item_t  out_item_r, out_item_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [prcc_pkg::HOOK_EN_W-1:0] hook_en_r, hook_en_nxt;
  logic [SLOTS-1:0]     ctrl_vld_r, ctrl_vld_nxt;
  logic [CNT_DEPTH-1:0] cnt_vld_r, cnt_vld_nxt;

  logic                 accept, wr_ok, issue, hit, en_bit;
  logic [prcc_pkg::HOOK_EN_W-1:0] en_shift;
  logic [AW-1:0]        waddr, raddr;
  logic                 we_addr, we_mask, we_port, we_ctrl, cnt_we;
  logic [63:0]          addr_q, mask_q, port_q, cnt_q, cnt_cur, cnt_new;
  logic [39:0]          ctrl_q, ctrl_eff;
  logic [CW-1:0]        cnt_idx;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign accept    = in_valid && in_ready;
  assign raddr     = base_r + AW'(s_r);
  assign cnt_idx   = ci_r[CW-1:0];
  assign ctrl_eff  = rdv_r ? ctrl_q : '0;
  assign cnt_cur   = cvld_r ? cnt_q : '0;
  assign cnt_new   = (&cnt_cur) ? cnt_cur : cnt_cur + 64'd1;
  assign en_shift  = hook_en_r >> in_item.hook;
  assign en_bit    = en_shift[0] && (32'(in_item.hook) < HOOK_COUNT);
  assign wr_ok     = (32'(in_item.hook) < HOOK_COUNT) && (32'(in_item.slot) < CHAIN_DEPTH);
  assign waddr     = AW'(32'(in_item.hook) * CHAIN_DEPTH + 32'(in_item.slot));
  assign issue     = (32'(s_r) < CHAIN_DEPTH);

  always_comb begin
    we_addr = 1'b0;
    we_mask = 1'b0;
    we_port = 1'b0;
    we_ctrl = 1'b0;
    if (accept && in_item.func == prcc_pkg::FUNC_WRITE && wr_ok) begin
      unique case (in_item.word_sel)
        prcc_pkg::SEL_ADDR: we_addr = 1'b1;
        prcc_pkg::SEL_MASK: we_mask = 1'b1;
        prcc_pkg::SEL_PORT: we_port = 1'b1;
        prcc_pkg::SEL_CTRL: we_ctrl = 1'b1;
        default:            we_ctrl = 1'b0;
      endcase
    end
  end

  prcc_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_addr_ram (
    .clk(clk), .we(we_addr), .waddr(waddr), .wdata(in_item.word_data),
    .raddr(raddr), .rdata(addr_q));
  prcc_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_mask_ram (
    .clk(clk), .we(we_mask), .waddr(waddr), .wdata(in_item.word_data),
    .raddr(raddr), .rdata(mask_q));
  prcc_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_port_ram (
    .clk(clk), .we(we_port), .waddr(waddr), .wdata(in_item.word_data),
    .raddr(raddr), .rdata(port_q));
  prcc_ram #(.WIDTH(prcc_pkg::CTRL_W), .DEPTH(SLOTS)) u_ctrl_ram (
    .clk(clk), .we(we_ctrl), .waddr(waddr), .wdata(in_item.word_data[39:0]),
    .raddr(raddr), .rdata(ctrl_q));
  prcc_ram #(.WIDTH(64), .DEPTH(CNT_DEPTH)) u_cnt_ram (
    .clk(clk), .we(cnt_we), .waddr(cnt_idx), .wdata(cnt_new),
    .raddr(cnt_idx), .rdata(cnt_q));

  prcc_match u_match (
    .pkt(pkt_r), .addr_w(addr_q), .mask_w(mask_q), .port_w(port_q),
    .ctrl_w(ctrl_eff), .hit(hit));

  always_comb begin
    state_nxt     = state_r;
    pkt_nxt       = pkt_r;
    base_nxt      = base_r;
    s_nxt         = s_r;
    pend_nxt      = 1'b0;
    rdv_nxt       = ctrl_vld_r[raddr];
    cvld_nxt      = cvld_r;
    ci_nxt        = ci_r;
    act_nxt       = act_r;
    id_nxt        = id_r;
    res_nxt       = res_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && !out_ready;
    hook_en_nxt   = cfg_we ? cfg_wdata : hook_en_r;
    ctrl_vld_nxt  = ctrl_vld_r;
    cnt_vld_nxt   = cnt_vld_r;
    cnt_we        = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (we_ctrl) begin
          ctrl_vld_nxt[waddr] = 1'b1;
        end
        if (accept && in_item.func == prcc_pkg::FUNC_CLASSIFY) begin
          pkt_nxt   = in_item;
          base_nxt  = AW'(32'(in_item.hook) * CHAIN_DEPTH);
          s_nxt     = '0;
          res_nxt   = '0;
          state_nxt = (en_bit && in_item.ports_ok) ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        pend_nxt = issue;
        if (issue) begin
          s_nxt = s_r + SW'(1);
        end
        if (pend_r) begin
          if (ctrl_eff[39:32] == '0) begin
            state_nxt = ST_DONE;
          end else if (hit) begin
            id_nxt    = ctrl_eff[39:32];
            ci_nxt    = ctrl_eff[39:32];
            act_nxt   = ctrl_eff[25:24];
            state_nxt = ST_MOD;
          end else if (!issue) begin
            state_nxt = ST_DONE;
          end
        end else if (!issue) begin
          state_nxt = ST_DONE;
        end
      end
      ST_MOD: begin
        if (32'(ci_r) >= RULE_IDS) begin
          ci_nxt = 8'(32'(ci_r) - RULE_IDS);
        end else begin
          state_nxt = ST_CRD;
        end
      end
      ST_CRD: begin
        cvld_nxt  = cnt_vld_r[cnt_idx];
        state_nxt = ST_CWR;
      end
      ST_CWR: begin
        cnt_we               = 1'b1;
        cnt_vld_nxt[cnt_idx] = 1'b1;
        res_nxt.matched      = 1'b1;
        res_nxt.action       = act_r;
        res_nxt.rule_id      = id_r;
        res_nxt.hit_count    = cnt_new;
        state_nxt            = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_item_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      hook_en_r   <= '0;
      ctrl_vld_r  <= '0;
      cnt_vld_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      hook_en_r   <= hook_en_nxt;
      ctrl_vld_r  <= ctrl_vld_nxt;
      cnt_vld_r   <= cnt_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pkt_r      <= pkt_nxt;
    base_r     <= base_nxt;
    s_r        <= s_nxt;
    rdv_r      <= rdv_nxt;
    cvld_r     <= cvld_nxt;
    ci_r       <= ci_nxt;
    act_r      <= act_nxt;
    id_r       <= id_nxt;
    res_r      <= res_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule
`default_nettype wire

### rtl/core/prcc_ram.sv
// Generic single write port, single read port RAM with registered read.
// Has no dependencies.
`timescale 1ns / 1ps
`default_nettype none
module prcc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 160,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

### rtl/core/prcc_match.sv
// Rule compare unit: tests one stored rule against the held packet header.
// Depends on prcc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module prcc_match (
  input  wire prcc_pkg::in_item_t    pkt,
  input  wire logic [63:0]           addr_w,
  input  wire logic [63:0]           mask_w,
  input  wire logic [63:0]           port_w,
  input  wire logic [39:0]           ctrl_w,
  output logic                       hit
);

  function automatic logic ip_ok(logic [31:0] p, logic [31:0] v, logic [31:0] m,
                                 logic [1:0] t);
    logic r;
    if (t == prcc_pkg::MT_ANY) begin
      r = (v == '0);
    end else if (t == prcc_pkg::MT_MASKED) begin
      r = (m == '0) ? (v == '0) : ((p & m) == (v & m));
    end else begin
      r = (p == v);
    end
    return r;
  endfunction

  function automatic logic port_ok(logic [15:0] p, logic [15:0] lo, logic [15:0] hi,
                                   logic [1:0] t);
    logic r;
    logic in_rng;
    in_rng = (p >= lo) && (p <= hi);
    if (t == prcc_pkg::MT_ANY) begin
      r = (lo == '0);
    end else if (t == prcc_pkg::MT_RANGE) begin
      r = (hi == '0) ? (p == lo) : in_rng;
    end else begin
      r = (hi != '0 && hi != lo) ? in_rng : (p == lo);
    end
    return r;
  endfunction

  logic [7:0] prot, pmsk, flags;
  logic       sip_pass, dip_pass, prot_pass, port_pass, l4;

  always_comb begin
    prot  = ctrl_w[7:0];
    pmsk  = ctrl_w[15:8];
    flags = ctrl_w[23:16];
    sip_pass = (addr_w[31:0] == '0 && mask_w[31:0] == '0) ||
               ip_ok(pkt.src_ip, addr_w[31:0], mask_w[31:0], flags[1:0]);
    dip_pass = (addr_w[63:32] == '0 && mask_w[63:32] == '0) ||
               ip_ok(pkt.dst_ip, addr_w[63:32], mask_w[63:32], flags[3:2]);
    if (prot == '0 && pmsk == '0) begin
      prot_pass = 1'b1;
    end else if (pmsk == '0) begin
      prot_pass = (pkt.protocol == prot);
    end else if (pkt.protocol == prcc_pkg::PROTO_TCP) begin
      prot_pass = (pmsk & prcc_pkg::PMASK_TCP) != '0;
    end else if (pkt.protocol == prcc_pkg::PROTO_UDP) begin
      prot_pass = (pmsk & prcc_pkg::PMASK_UDP) != '0;
    end else if (pkt.protocol == prcc_pkg::PROTO_ICMP) begin
      prot_pass = (pmsk & prcc_pkg::PMASK_ICMP) != '0;
    end else begin
      prot_pass = 1'b0;
    end
    l4 = (pkt.protocol == prcc_pkg::PROTO_TCP) || (pkt.protocol == prcc_pkg::PROTO_UDP);
    port_pass = !l4 ||
                (port_ok(pkt.sport, port_w[15:0], port_w[31:16], flags[5:4]) &&
                 port_ok(pkt.dport, port_w[47:32], port_w[63:48], flags[7:6]));
    hit = sip_pass && dip_pass && prot_pass && port_pass;
  end

endmodule
`default_nettype wire

### rtl/core/prcc_checker.sv
// Port-level checker for the packet rule chain classifier, bound to the top level.
// Depends on prcc_pkg and packet_rule_chain_classifier_core.
`timescale 1ns / 1ps
`default_nettype none
module prcc_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire prcc_pkg::in_item_t  in_item,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire prcc_pkg::out_item_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("A stalled result changed before its transfer.");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("A result was shown straight after reset.");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.matched |->
      out_item.action == '0 && out_item.rule_id == '0 && out_item.hit_count == '0)
    else $error("A result without a match carries nonzero fields.");

  a_hit_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.matched |-> out_item.rule_id != '0 && out_item.hit_count != '0)
    else $error("A matching result has a zero rule id or count.");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_item.func == prcc_pkg::FUNC_CLASSIFY |=> !in_ready)
    else $error("The block took a new item straight after a classify transfer.");

endmodule

bind packet_rule_chain_classifier_core prcc_checker u_prcc_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .in_item(in_item), .out_valid(out_valid), .out_ready(out_ready),
  .out_item(out_item));
`default_nettype wire
